// ===== hw/rtl/sdis_pkg.sv =====
// Shared types, codes and result builders for the SD card init sequencer.
// No dependencies; every other file of the block imports this package.
package sdis_pkg;

	localparam int SWITCH_STATUS_BYTES = 64;

	typedef enum logic [2:0] {
		OP_START  = 3'd0,
		OP_TICK   = 3'd1,
		OP_RESULT = 3'd2,
		OP_DATA   = 3'd3,
		OP_READ   = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		KIND_CMD       = 3'd0,
		KIND_CLOCK     = 3'd1,
		KIND_WIDE_BUS  = 3'd2,
		KIND_HIGH_SPD  = 3'd3,
		KIND_DONE_OK   = 3'd4,
		KIND_DONE_FAIL = 3'd5
	} kind_t;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'd0,
		PH_CMD0   = 5'd1,
		PH_CMD8   = 5'd2,
		PH_GAP8   = 5'd3,
		PH_CMD55I = 5'd4,
		PH_ACMD41 = 5'd5,
		PH_GAP41  = 5'd6,
		PH_CMD2   = 5'd7,
		PH_CMD3   = 5'd8,
		PH_CMD9   = 5'd9,
		PH_CMD7   = 5'd10,
		PH_CMD55W = 5'd11,
		PH_ACMD6  = 5'd12,
		PH_CMD16  = 5'd13,
		PH_CMD6   = 5'd14,
		PH_READY  = 5'd15,
		PH_CMD17  = 5'd16,
		PH_FAILED = 5'd17
	} phase_t;

	// response types
	localparam logic [1:0] RT_NONE = 2'd0;
	localparam logic [1:0] RT_R136 = 2'd1;
	localparam logic [1:0] RT_R48  = 2'd2;
	localparam logic [1:0] RT_R48B = 2'd3;

	// fail codes
	localparam logic [3:0] FAIL_NONE   = 4'd0;
	localparam logic [3:0] FAIL_CMD8   = 4'd1;
	localparam logic [3:0] FAIL_ACMD41 = 4'd2;
	localparam logic [3:0] FAIL_CMD2   = 4'd3;
	localparam logic [3:0] FAIL_CMD3   = 4'd4;
	localparam logic [3:0] FAIL_CMD9   = 4'd5;
	localparam logic [3:0] FAIL_CMD7   = 4'd6;
	localparam logic [3:0] FAIL_ACMD6  = 4'd7;
	localparam logic [3:0] FAIL_CMD16  = 4'd8;
	localparam logic [3:0] FAIL_CMD17  = 4'd9;

	// configuration register indexes
	localparam logic [1:0] CFG_RETRY_WINDOW = 2'd0;
	localparam logic [1:0] CFG_RETRY_GAP    = 2'd1;
	localparam logic [1:0] CFG_WIDE_BUS     = 2'd2;
	localparam logic [1:0] CFG_HIGH_SPEED   = 2'd3;

	// command numbers
	localparam logic [5:0] SD_CMD0  = 6'd0;
	localparam logic [5:0] SD_CMD2  = 6'd2;
	localparam logic [5:0] SD_CMD3  = 6'd3;
	localparam logic [5:0] SD_CMD6  = 6'd6;
	localparam logic [5:0] SD_CMD7  = 6'd7;
	localparam logic [5:0] SD_CMD8  = 6'd8;
	localparam logic [5:0] SD_CMD9  = 6'd9;
	localparam logic [5:0] SD_CMD16 = 6'd16;
	localparam logic [5:0] SD_CMD17 = 6'd17;
	localparam logic [5:0] SD_ACMD41 = 6'd41;
	localparam logic [5:0] SD_CMD55 = 6'd55;

	// command arguments and status positions
	localparam logic [31:0] ARG_CMD8_CHECK = 32'h0000_01aa;
	localparam logic [31:0] ARG_ACMD41_OCR = 32'h00ff_8000;
	localparam logic [31:0] ARG_CMD6_SWITCH = 32'h00ff_fff1;
	localparam logic [31:0] ARG_BLOCK_LEN  = 32'd512;
	localparam logic [31:0] ARG_BUS_4BIT   = 32'd2;
	localparam logic [5:0]  STATUS_IDX_D   = 6'h0d;
	localparam logic [5:0]  STATUS_IDX_10  = 6'h10;
	localparam logic [3:0]  SHIFT_BYTE_ADDR = 4'd9;
	localparam logic [3:0]  SHIFT_BLOCK_ADDR = 4'd0;
	localparam logic [7:0]  DIV_25MHZ = 8'd1;
	localparam logic [7:0]  DIV_50MHZ = 8'd0;

	localparam logic [15:0] RESET_RETRY_WINDOW = 16'd500;
	localparam logic [7:0]  RESET_RETRY_GAP    = 8'd5;

	typedef struct packed {
		opcode_t     opcode;
		logic        cmd_complete;
		logic        cmd_timeout;
		logic        cmd_error;
		logic [31:0] resp_word;
		logic [7:0]  data_byte;
		logic [5:0]  data_index;
		logic [31:0] block_index;
	} evt_t;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  cmd_index;
		logic [31:0] cmd_arg;
		logic [1:0]  resp_type;
		logic        check_index;
		logic        check_crc;
		logic        has_data;
		logic [7:0]  clock_divider;
		logic [3:0]  fail_code;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [15:0] retry_window_ms;
		logic [7:0]  retry_gap_ms;
		logic        wide_bus_enable;
		logic        high_speed_enable;
	} cfg_t;

	// up to two results from one request, in order r0 then r1
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] elapsed_ms;
		logic [7:0]  gap_count;
		logic        card_v2;
		logic [15:0] card_address;
		logic [1:0]  switch_pass;
		logic [7:0]  status_byte_d;
		logic [7:0]  status_byte_10;
		logic [3:0]  address_shift;
	} seq_state_t;

	function automatic res_t mk_cmd(input logic [5:0] idx, input logic [31:0] arg,
			input logic [1:0] rt, input logic ci, input logic cc, input logic hd);
		res_t r;
		r = '0;
		r.kind = KIND_CMD;
		r.cmd_index = idx;
		r.cmd_arg = arg;
		r.resp_type = rt;
		r.check_index = ci;
		r.check_crc = cc;
		r.has_data = hd;
		return r;
	endfunction

	function automatic res_t mk_note(input kind_t k, input logic [7:0] div,
			input logic [3:0] fc);
		res_t r;
		r = '0;
		r.kind = k;
		r.clock_divider = div;
		r.fail_code = fc;
		return r;
	endfunction

endpackage

// ===== hw/rtl/sdis_ifs.sv =====
// Valid/ready channel interfaces for event requests and sequencer results.
// Depends on sdis_pkg for the payload types.
interface sdis_evt_if;
	import sdis_pkg::*;
	logic valid;
	logic ready;
	evt_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface sdis_res_if;
	import sdis_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/sd_card_init_sequencer.sv =====
// Top level of the SD card bring-up sequencer: config registers, phase logic
// and result queue. Depends on sdis_pkg, sdis_ifs, sdis_cfg_regs, sdis_core, sdis_res_fifo.
//
//   channel  dir   handshake      payload
//   evt      in    valid/ready    evt_t: opcode, result flags, response, data, block
//   res      out   valid/ready    res_t: kind, command fields, divider, fail code, last
//   cfg      in    cfg_we only    cfg_index selects register, cfg_data carries value
//
// Each request is applied in the cycle it is accepted, so one request per cycle is taken
// while evt.ready is high; its zero, one or two results enter the queue at that edge and
// leave one per res handshake, the first visible in the cycle after acceptance. evt.ready
// drops while fewer than two queue slots are free, so a stalled res side stalls evt only
// once the queue holds RES_DEPTH - 1 entries. Reset is asynchronous and puts the phase
// at idle and the config registers at their defaults; there is no clearing pass.
module sd_card_init_sequencer #(
	parameter int RES_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	sdis_evt_if.sink    evt,
	sdis_res_if.source  res
);
	import sdis_pkg::*;

	cfg_t  cfg;
	push_t push;
	logic  room;
	logic  accept;

	// advance the phase only on an accepted request
	assign accept    = evt.valid && evt.ready;
	assign evt.ready = room;

	sdis_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_data),
		.cfg    (cfg)
	);

	sdis_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.evt    (evt.data),
		.cfg    (cfg),
		.push   (push)
	);

	sdis_res_fifo #(
		.DEPTH (RES_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.valid  (res.valid),
		.ready  (res.ready),
		.head   (res.data)
	);

	// a start always produces CMD0, so a result must be waiting next cycle
	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && evt.data.opcode == OP_START |=> res.valid)
		else $error("start request produced no result");

	// a failure report closes its request and carries a code
	a_fail_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.kind == KIND_DONE_FAIL |->
			res.data.last && res.data.fail_code != FAIL_NONE)
		else $error("failure result without code or last mark");

	// back-pressure on requests only comes from queued results
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!evt.ready |-> res.valid)
		else $error("request stalled with empty result queue");
endmodule

// ===== hw/rtl/sdis_cfg_regs.sv =====
// Configuration registers of the SD card init sequencer.
// Depends on sdis_pkg for the register indexes and cfg_t.
module sdis_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [1:0]       index,
	input  logic [15:0]      wdata,
	output sdis_pkg::cfg_t   cfg
);
	import sdis_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.retry_window_ms   <= RESET_RETRY_WINDOW;
			cfg_q.retry_gap_ms      <= RESET_RETRY_GAP;
			cfg_q.wide_bus_enable   <= 1'b1;
			cfg_q.high_speed_enable <= 1'b1;
		end else if (we) begin
			case (index)
				CFG_RETRY_WINDOW: cfg_q.retry_window_ms <= wdata;
				CFG_RETRY_GAP:    cfg_q.retry_gap_ms <= wdata[7:0];
				CFG_WIDE_BUS:     cfg_q.wide_bus_enable <= wdata[0];
				CFG_HIGH_SPEED:   cfg_q.high_speed_enable <= wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== hw/rtl/sdis_core.sv =====
// Phase register and combinational next-phase/result logic of the sequencer.
// Depends on sdis_pkg; feeds up to two results per request into the result queue.
module sdis_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  sdis_pkg::evt_t    evt,
	input  sdis_pkg::cfg_t    cfg,
	output sdis_pkg::push_t   push
);
	import sdis_pkg::*;

	localparam seq_state_t ST_RESET = '{
		phase:          PH_IDLE,
		elapsed_ms:     16'd0,
		gap_count:      8'd0,
		card_v2:        1'b0,
		card_address:   16'd0,
		switch_pass:    2'd0,
		status_byte_d:  8'd0,
		status_byte_10: 8'd0,
		address_shift:  SHIFT_BYTE_ADDR
	};

	seq_state_t st_q;
	seq_state_t st_d;
	push_t      p;
	logic [31:0] resp;
	logic [31:0] rca;
	logic        window_over;
	logic        acmd41_retry;
	logic [7:0]  gap_next;

	always_comb begin
		st_d = st_q;
		p = '0;
		resp = evt.cmd_error ? 32'd0 : evt.resp_word;
		rca = {st_q.card_address, 16'd0};
		window_over = st_q.elapsed_ms > cfg.retry_window_ms;
		acmd41_retry = evt.cmd_timeout || (evt.cmd_complete && !resp[31]);
		gap_next = st_q.gap_count - 8'd1;

		case (evt.opcode)
			OP_START: begin
				st_d = '0;
				st_d.address_shift = SHIFT_BYTE_ADDR;
				st_d.phase = PH_CMD0;
				p.n = 2'd1;
				p.r0 = mk_cmd(SD_CMD0, 32'd0, RT_NONE, 1'b0, 1'b0, 1'b0);
			end
			OP_TICK: begin
				if (st_q.phase == PH_CMD8 || st_q.phase == PH_GAP8 ||
						st_q.phase == PH_CMD55I || st_q.phase == PH_ACMD41 ||
						st_q.phase == PH_GAP41) begin
					if (st_q.elapsed_ms != 16'hffff)
						st_d.elapsed_ms = st_q.elapsed_ms + 16'd1;
					if (st_q.phase == PH_GAP8 || st_q.phase == PH_GAP41) begin
						st_d.gap_count = gap_next;
						if (gap_next == 8'd0) begin
							p.n = 2'd1;
							if (st_q.phase == PH_GAP8) begin
								p.r0 = mk_cmd(SD_CMD8, ARG_CMD8_CHECK, RT_R48, 1'b1, 1'b1, 1'b0);
								st_d.phase = PH_CMD8;
							end else begin
								p.r0 = mk_cmd(SD_CMD55, 32'd0, RT_R48, 1'b1, 1'b1, 1'b0);
								st_d.phase = PH_CMD55I;
							end
						end
					end
				end
			end
			OP_RESULT: begin
				case (st_q.phase)
					PH_CMD0: begin
						st_d.elapsed_ms = 16'd0;
						p.n = 2'd1;
						p.r0 = mk_cmd(SD_CMD8, ARG_CMD8_CHECK, RT_R48, 1'b1, 1'b1, 1'b0);
						st_d.phase = PH_CMD8;
					end
					PH_CMD8: begin
						if (evt.cmd_timeout) begin
							if (window_over) begin
								st_d.card_v2 = 1'b0;
								st_d.elapsed_ms = 16'd0;
								p.n = 2'd1;
								p.r0 = mk_cmd(SD_CMD55, 32'd0, RT_R48, 1'b1, 1'b1, 1'b0);
								st_d.phase = PH_CMD55I;
							end else if (cfg.retry_gap_ms == 8'd0) begin
								p.n = 2'd1;
								p.r0 = mk_cmd(SD_CMD8, ARG_CMD8_CHECK, RT_R48, 1'b1, 1'b1, 1'b0);
							end else begin
								st_d.gap_count = cfg.retry_gap_ms;
								st_d.phase = PH_GAP8;
							end
						end else if (evt.cmd_complete && resp == ARG_CMD8_CHECK) begin
							st_d.card_v2 = 1'b1;
							st_d.elapsed_ms = 16'd0;
							p.n = 2'd1;
							p.r0 = mk_cmd(SD_CMD55, 32'd0, RT_R48, 1'b1, 1'b1, 1'b0);
							st_d.phase = PH_CMD55I;
						end else begin
							p.n = 2'd1;
							p.r0 = mk_note(KIND_DONE_FAIL, 8'd0, FAIL_CMD8);
							st_d.phase = PH_FAILED;
						end
					end
					PH_CMD55I, PH_ACMD41: begin
						if (st_q.phase == PH_CMD55I && evt.cmd_complete) begin
							p.n = 2'd1;
							p.r0 = mk_cmd(SD_ACMD41, ARG_ACMD41_OCR | {1'b0, st_q.card_v2, 30'd0},
								RT_R48, 1'b0, 1'b0, 1'b0);
							st_d.phase = PH_ACMD41;
						end else if (st_q.phase == PH_CMD55I && !evt.cmd_timeout) begin
							p.n = 2'd1;
							p.r0 = mk_note(KIND_DONE_FAIL, 8'd0, FAIL_ACMD41);
							st_d.phase = PH_FAILED;
						end else if (st_q.phase == PH_ACMD41 && acmd41_retry && !window_over ||
								st_q.phase == PH_CMD55I && !window_over) begin
							if (cfg.retry_gap_ms == 8'd0) begin
								p.n = 2'd1;
								p.r0 = mk_cmd(SD_CMD55, 32'd0, RT_R48, 1'b1, 1'b1, 1'b0);
								st_d.phase = PH_CMD55I;
							end else begin
								st_d.gap_count = cfg.retry_gap_ms;
								st_d.phase = PH_GAP41;
							end
						end else if (st_q.phase == PH_ACMD41 && evt.cmd_complete) begin
							// leave the loop: pick block or byte addressing
							st_d.address_shift = (st_q.card_v2 && resp[30]) ?
								SHIFT_BLOCK_ADDR : SHIFT_BYTE_ADDR;
							p.n = 2'd1;
							p.r0 = mk_cmd(SD_CMD2, 32'd0, RT_R136, 1'b0, 1'b1, 1'b0);
							st_d.phase = PH_CMD2;
						end else begin
							p.n = 2'd1;
							p.r0 = mk_note(KIND_DONE_FAIL, 8'd0, FAIL_ACMD41);
							st_d.phase = PH_FAILED;
						end
					end
					PH_CMD2: begin
						p.n = 2'd1;
						if (evt.cmd_complete) begin
							p.r0 = mk_cmd(SD_CMD3, 32'd0, RT_R48, 1'b1, 1'b1, 1'b0);
							st_d.phase = PH_CMD3;
						end else begin
							p.r0 = mk_note(KIND_DONE_FAIL, 8'd0, FAIL_CMD2);
							st_d.phase = PH_FAILED;
						end
					end
					PH_CMD3: begin
						p.n = 2'd1;
						if (evt.cmd_complete) begin
							st_d.card_address = resp[31:16];
							p.r0 = mk_cmd(SD_CMD9, {resp[31:16], 16'd0}, RT_R136, 1'b0, 1'b1, 1'b0);
							st_d.phase = PH_CMD9;
						end else begin
							p.r0 = mk_note(KIND_DONE_FAIL, 8'd0, FAIL_CMD3);
							st_d.phase = PH_FAILED;
						end
					end
					PH_CMD9: begin
						if (evt.cmd_complete) begin
							p.n = 2'd2;
							p.r0 = mk_note(KIND_CLOCK, DIV_25MHZ, FAIL_NONE);
							p.r1 = mk_cmd(SD_CMD7, rca, RT_R48B, 1'b1, 1'b1, 1'b0);
							st_d.phase = PH_CMD7;
						end else begin
							p.n = 2'd1;
							p.r0 = mk_note(KIND_DONE_FAIL, 8'd0, FAIL_CMD9);
							st_d.phase = PH_FAILED;
						end
					end
					PH_CMD7: begin
						p.n = 2'd1;
						if (!evt.cmd_complete) begin
							p.r0 = mk_note(KIND_DONE_FAIL, 8'd0, FAIL_CMD7);
							st_d.phase = PH_FAILED;
						end else if (cfg.wide_bus_enable) begin
							p.r0 = mk_cmd(SD_CMD55, rca, RT_R48, 1'b1, 1'b1, 1'b0);
							st_d.phase = PH_CMD55W;
						end else begin
							p.r0 = mk_cmd(SD_CMD16, ARG_BLOCK_LEN, RT_R48, 1'b1, 1'b1, 1'b0);
							st_d.phase = PH_CMD16;
						end
					end
					PH_CMD55W: begin
						p.n = 2'd1;
						if (evt.cmd_complete) begin
							p.r0 = mk_cmd(SD_CMD6, ARG_BUS_4BIT, RT_R48, 1'b1, 1'b1, 1'b0);
							st_d.phase = PH_ACMD6;
						end else begin
							p.r0 = mk_note(KIND_DONE_FAIL, 8'd0, FAIL_ACMD6);
							st_d.phase = PH_FAILED;
						end
					end
					PH_ACMD6: begin
						if (evt.cmd_complete) begin
							p.n = 2'd2;
							p.r0 = mk_note(KIND_WIDE_BUS, 8'd0, FAIL_NONE);
							p.r1 = mk_cmd(SD_CMD16, ARG_BLOCK_LEN, RT_R48, 1'b1, 1'b1, 1'b0);
							st_d.phase = PH_CMD16;
						end else begin
							p.n = 2'd1;
							p.r0 = mk_note(KIND_DONE_FAIL, 8'd0, FAIL_ACMD6);
							st_d.phase = PH_FAILED;
						end
					end
					PH_CMD16: begin
						if (!evt.cmd_complete) begin
							p.n = 2'd1;
							p.r0 = mk_note(KIND_DONE_FAIL, 8'd0, FAIL_CMD16);
							st_d.phase = PH_FAILED;
						end else if (cfg.high_speed_enable) begin
							st_d.switch_pass = 2'd0;
							st_d.status_byte_d = 8'd0;
							st_d.status_byte_10 = 8'd0;
							p.n = 2'd2;
							p.r0 = mk_note(KIND_HIGH_SPD, 8'd0, FAIL_NONE);
							p.r1 = mk_cmd(SD_CMD6, ARG_CMD6_SWITCH, RT_R48, 1'b1, 1'b1, 1'b1);
							st_d.phase = PH_CMD6;
						end else begin
							p.n = 2'd1;
							p.r0 = mk_note(KIND_DONE_OK, 8'd0, FAIL_NONE);
							st_d.phase = PH_READY;
						end
					end
					PH_CMD6: begin
						if (!evt.cmd_complete || st_q.status_byte_10[3:0] != 4'd1 ||
								!st_q.status_byte_d[1]) begin
							// switch refused: stay at 25 MHz
							p.n = 2'd1;
							p.r0 = mk_note(KIND_DONE_OK, 8'd0, FAIL_NONE);
							st_d.phase = PH_READY;
						end else if (st_q.switch_pass == 2'd0) begin
							st_d.switch_pass = 2'd1;
							st_d.status_byte_d = 8'd0;
							st_d.status_byte_10 = 8'd0;
							p.n = 2'd1;
							p.r0 = mk_cmd(SD_CMD6, ARG_CMD6_SWITCH | 32'h8000_0000,
								RT_R48, 1'b1, 1'b1, 1'b1);
						end else begin
							st_d.switch_pass = 2'd2;
							p.n = 2'd2;
							p.r0 = mk_note(KIND_CLOCK, DIV_50MHZ, FAIL_NONE);
							p.r1 = mk_note(KIND_DONE_OK, 8'd0, FAIL_NONE);
							st_d.phase = PH_READY;
						end
					end
					PH_CMD17: begin
						p.n = 2'd1;
						if (evt.cmd_complete) begin
							p.r0 = mk_note(KIND_DONE_OK, 8'd0, FAIL_NONE);
							st_d.phase = PH_READY;
						end else begin
							p.r0 = mk_note(KIND_DONE_FAIL, 8'd0, FAIL_CMD17);
							st_d.phase = PH_FAILED;
						end
					end
					default: ;
				endcase
			end
			OP_DATA: begin
				if (st_q.phase == PH_CMD6 &&
						{26'd0, evt.data_index} < 32'(SWITCH_STATUS_BYTES)) begin
					if (evt.data_index == STATUS_IDX_D)
						st_d.status_byte_d = evt.data_byte;
					else if (evt.data_index == STATUS_IDX_10)
						st_d.status_byte_10 = evt.data_byte;
				end
			end
			OP_READ: begin
				if (st_q.phase == PH_READY) begin
					p.n = 2'd1;
					p.r0 = mk_cmd(SD_CMD17, evt.block_index << st_q.address_shift,
						RT_R48, 1'b1, 1'b1, 1'b1);
					st_d.phase = PH_CMD17;
				end
			end
			default: ;
		endcase

		if (p.n == 2'd1)
			p.r0.last = 1'b1;
		else if (p.n == 2'd2)
			p.r1.last = 1'b1;
		if (!accept)
			p.n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (accept) begin
			st_q <= st_d;
		end
	end

	assign push = p;
endmodule

// ===== hw/rtl/sdis_res_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one per handshake.
// Depends on sdis_pkg for res_t and push_t.
module sdis_res_fifo #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sdis_pkg::push_t  push,
	output logic             room,
	output logic             valid,
	input  logic             ready,
	output sdis_pkg::res_t   head
);
	import sdis_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	res_t          mem [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] wr1;
	logic          pop;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] ptr);
		return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
	endfunction

	assign wr1   = bump(wr_q);
	assign valid = count_q != '0;
	assign pop   = valid && ready;
	// hold off new requests unless two free slots remain
	assign room  = count_q <= CW'(DEPTH - 2);
	assign head  = mem[rd_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (push.n != 2'd0 && wr_q == PW'(i))
				mem[i] <= push.r0;
			if (push.n == 2'd2 && wr1 == PW'(i))
				mem[i] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push.n == 2'd1)
				wr_q <= wr1;
			else if (push.n == 2'd2)
				wr_q <= bump(wr1);
			if (pop)
				rd_q <= bump(rd_q);
			count_q <= count_q + CW'(push.n) - CW'(pop);
		end
	end
endmodule

// ===== bench/sd_card_init_sequencer_tb.sv =====
// Self-checking bench for sd_card_init_sequencer: phase-aware request stimulus,
// an in-bench model of the bring-up sequence and an in-order result scoreboard.
// Depends on sdis_pkg, the sdis_ifs channel interfaces and the block's RTL.
module sd_card_init_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sdis_pkg::*;

	// cycles without any accepted request or result before the run is abandoned
	localparam int unsigned STALL_LIMIT = 2000;
	// cycles a request with no result may still be in flight inside the block
	localparam int unsigned DRAIN_CYCLES = 4;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	sdis_evt_if evt_ch();
	sdis_res_if res_ch();

	sd_card_init_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.evt       (evt_ch),
		.res       (res_ch)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Model of the sequencer: configuration and sequence state
	// ------------------------------------------------------------------
	logic [15:0] window_ms;
	logic [7:0]  gap_ms;
	logic        wide_en;
	logic        hs_en;

	phase_t      seq_phase;
	logic [15:0] ms_elapsed;
	logic [7:0]  gap_left;
	logic        card_v2;
	logic [15:0] rca_latched;
	logic [1:0]  switch_pass;
	logic [7:0]  sw_byte_d;
	logic [7:0]  sw_byte_10;
	logic [3:0]  addr_shift;

	res_t step_out[$];        // results caused by the request being modeled
	res_t pending_results[$]; // predicted results not yet seen on res
	res_t head_result;

	int unsigned errors;
	int unsigned idle_cycles;
	int unsigned res_stall_left;
	bit          evt_steady;
	bit          res_steady;

	function automatic void issue(input logic [5:0] idx, input logic [31:0] arg,
			input logic [1:0] rt, input logic ci, input logic cc, input logic hd,
			input phase_t nxt);
		res_t r;
		r = '0;
		r.kind = KIND_CMD;
		r.cmd_index = idx;
		r.cmd_arg = arg;
		r.resp_type = rt;
		r.check_index = ci;
		r.check_crc = cc;
		r.has_data = hd;
		step_out.push_back(r);
		seq_phase = nxt;
	endfunction

	function automatic void notice(input kind_t k, input logic [7:0] div,
			input logic [3:0] fc);
		res_t r;
		r = '0;
		r.kind = k;
		r.clock_divider = div;
		r.fail_code = fc;
		step_out.push_back(r);
	endfunction

	function automatic void fail_sequence(input logic [3:0] fc);
		notice(KIND_DONE_FAIL, 8'd0, fc);
		seq_phase = PH_FAILED;
	endfunction

	function automatic void finish_ok();
		notice(KIND_DONE_OK, 8'd0, FAIL_NONE);
		seq_phase = PH_READY;
	endfunction

	function automatic void send_cmd8();
		issue(SD_CMD8, ARG_CMD8_CHECK, RT_R48, 1'b1, 1'b1, 1'b0, PH_CMD8);
	endfunction

	function automatic void send_cmd55_init();
		issue(SD_CMD55, 32'd0, RT_R48, 1'b1, 1'b1, 1'b0, PH_CMD55I);
	endfunction

	// each switch pass starts with a clean status capture; pass 1 sets the mode bit
	function automatic void send_switch();
		sw_byte_d = 8'd0;
		sw_byte_10 = 8'd0;
		issue(SD_CMD6, ARG_CMD6_SWITCH | {switch_pass[0], 31'd0}, RT_R48,
			1'b1, 1'b1, 1'b1, PH_CMD6);
	endfunction

	function automatic void start_op_cond_loop();
		ms_elapsed = 16'd0;
		send_cmd55_init();
	endfunction

	// CCS picks block addressing, but only on a version 2 card
	function automatic void leave_op_cond(input logic comp, input logic [31:0] resp);
		if (!comp) begin
			fail_sequence(FAIL_ACMD41);
			return;
		end
		addr_shift = (card_v2 && resp[30]) ? SHIFT_BLOCK_ADDR : SHIFT_BYTE_ADDR;
		issue(SD_CMD2, 32'd0, RT_R136, 1'b0, 1'b1, 1'b0, PH_CMD2);
	endfunction

	function automatic void retry_if_cond();
		if (ms_elapsed > window_ms) begin
			card_v2 = 1'b0;
			start_op_cond_loop();
		end else if (gap_ms == 8'd0) begin
			send_cmd8();
		end else begin
			gap_left = gap_ms;
			seq_phase = PH_GAP8;
		end
	endfunction

	function automatic void retry_op_cond(input logic comp, input logic [31:0] resp);
		if (ms_elapsed > window_ms) begin
			leave_op_cond(comp, resp);
		end else if (gap_ms == 8'd0) begin
			send_cmd55_init();
		end else begin
			gap_left = gap_ms;
			seq_phase = PH_GAP41;
		end
	endfunction

	function automatic void model_tick();
		if (seq_phase < PH_CMD8 || seq_phase > PH_GAP41)
			return;
		if (ms_elapsed != 16'hffff)
			ms_elapsed++;
		if (seq_phase == PH_GAP8 || seq_phase == PH_GAP41) begin
			gap_left--;
			if (gap_left == 8'd0) begin
				if (seq_phase == PH_GAP8)
					send_cmd8();
				else
					send_cmd55_init();
			end
		end
	endfunction

	function automatic void model_result(input logic comp, input logic tmo,
			input logic [31:0] resp);
		logic [31:0] rca_arg;
		rca_arg = {rca_latched, 16'd0};
		case (seq_phase)
			PH_CMD0: begin
				ms_elapsed = 16'd0;
				send_cmd8();
			end
			PH_CMD8: begin
				if (tmo) begin
					retry_if_cond();
				end else if (comp && resp == ARG_CMD8_CHECK) begin
					card_v2 = 1'b1;
					start_op_cond_loop();
				end else begin
					fail_sequence(FAIL_CMD8);
				end
			end
			PH_CMD55I: begin
				if (comp)
					issue(SD_ACMD41, ARG_ACMD41_OCR | {1'b0, card_v2, 30'd0}, RT_R48,
						1'b0, 1'b0, 1'b0, PH_ACMD41);
				else if (tmo)
					retry_op_cond(1'b0, resp);
				else
					fail_sequence(FAIL_ACMD41);
			end
			PH_ACMD41: begin
				if (tmo || (comp && !resp[31]))
					retry_op_cond(comp, resp);
				else
					leave_op_cond(comp, resp);
			end
			PH_CMD2: begin
				if (comp)
					issue(SD_CMD3, 32'd0, RT_R48, 1'b1, 1'b1, 1'b0, PH_CMD3);
				else
					fail_sequence(FAIL_CMD2);
			end
			PH_CMD3: begin
				if (!comp) begin
					fail_sequence(FAIL_CMD3);
				end else begin
					rca_latched = resp[31:16];
					issue(SD_CMD9, {resp[31:16], 16'd0}, RT_R136, 1'b0, 1'b1, 1'b0,
						PH_CMD9);
				end
			end
			PH_CMD9: begin
				if (!comp) begin
					fail_sequence(FAIL_CMD9);
				end else begin
					notice(KIND_CLOCK, DIV_25MHZ, FAIL_NONE);
					issue(SD_CMD7, rca_arg, RT_R48B, 1'b1, 1'b1, 1'b0, PH_CMD7);
				end
			end
			PH_CMD7: begin
				if (!comp)
					fail_sequence(FAIL_CMD7);
				else if (wide_en)
					issue(SD_CMD55, rca_arg, RT_R48, 1'b1, 1'b1, 1'b0, PH_CMD55W);
				else
					issue(SD_CMD16, ARG_BLOCK_LEN, RT_R48, 1'b1, 1'b1, 1'b0, PH_CMD16);
			end
			PH_CMD55W: begin
				if (comp)
					issue(SD_CMD6, ARG_BUS_4BIT, RT_R48, 1'b1, 1'b1, 1'b0, PH_ACMD6);
				else
					fail_sequence(FAIL_ACMD6);
			end
			PH_ACMD6: begin
				if (!comp) begin
					fail_sequence(FAIL_ACMD6);
				end else begin
					notice(KIND_WIDE_BUS, 8'd0, FAIL_NONE);
					issue(SD_CMD16, ARG_BLOCK_LEN, RT_R48, 1'b1, 1'b1, 1'b0, PH_CMD16);
				end
			end
			PH_CMD16: begin
				if (!comp) begin
					fail_sequence(FAIL_CMD16);
				end else if (hs_en) begin
					notice(KIND_HIGH_SPD, 8'd0, FAIL_NONE);
					switch_pass = 2'd0;
					send_switch();
				end else begin
					finish_ok();
				end
			end
			PH_CMD6: begin
				// a refused switch still leaves a usable card at 25 MHz
				if (!comp || sw_byte_10[3:0] != 4'h1 || !sw_byte_d[1]) begin
					finish_ok();
				end else if (switch_pass == 2'd0) begin
					switch_pass = 2'd1;
					send_switch();
				end else begin
					switch_pass = 2'd2;
					notice(KIND_CLOCK, DIV_50MHZ, FAIL_NONE);
					finish_ok();
				end
			end
			PH_CMD17: begin
				if (comp)
					finish_ok();
				else
					fail_sequence(FAIL_CMD17);
			end
			default: ;
		endcase
	endfunction

	// Advance the model by one accepted request and queue what it must produce.
	function automatic void advance_sequencer(input evt_t e);
		logic [31:0] resp;
		resp = e.cmd_error ? 32'd0 : e.resp_word;
		step_out.delete();
		case (e.opcode)
			OP_START: begin
				ms_elapsed = 16'd0;
				gap_left = 8'd0;
				card_v2 = 1'b0;
				rca_latched = 16'd0;
				switch_pass = 2'd0;
				sw_byte_d = 8'd0;
				sw_byte_10 = 8'd0;
				addr_shift = SHIFT_BYTE_ADDR;
				issue(SD_CMD0, 32'd0, RT_NONE, 1'b0, 1'b0, 1'b0, PH_CMD0);
			end
			OP_TICK: model_tick();
			OP_RESULT: model_result(e.cmd_complete, e.cmd_timeout, resp);
			OP_DATA: begin
				if (seq_phase == PH_CMD6) begin
					if (e.data_index == STATUS_IDX_D)
						sw_byte_d = e.data_byte;
					else if (e.data_index == STATUS_IDX_10)
						sw_byte_10 = e.data_byte;
				end
			end
			OP_READ: begin
				if (seq_phase == PH_READY)
					issue(SD_CMD17, e.block_index << addr_shift, RT_R48, 1'b1, 1'b1,
						1'b1, PH_CMD17);
			end
			default: ;
		endcase
		if (step_out.size() != 0)
			step_out[step_out.size() - 1].last = 1'b1;
		foreach (step_out[i])
			pending_results.push_back(step_out[i]);
	endfunction

	// ------------------------------------------------------------------
	// Request builders
	// ------------------------------------------------------------------
	function automatic bit coin();
		return bit'($urandom_range(0, 1));
	endfunction

	function automatic bit flip(input int unsigned pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// fields that the opcode ignores still carry random values
	function automatic evt_t random_fill();
		evt_t e;
		e.opcode = OP_TICK;
		e.cmd_complete = coin();
		e.cmd_timeout = coin();
		e.cmd_error = coin();
		e.resp_word = $urandom;
		e.data_byte = 8'($urandom);
		e.data_index = 6'($urandom);
		e.block_index = $urandom;
		return e;
	endfunction

	function automatic evt_t ev_start();
		evt_t e;
		e = random_fill();
		e.opcode = OP_START;
		return e;
	endfunction

	function automatic evt_t ev_tick();
		return random_fill();
	endfunction

	function automatic evt_t ev_result(input logic c, input logic t, input logic er,
			input logic [31:0] w);
		evt_t e;
		e = random_fill();
		e.opcode = OP_RESULT;
		e.cmd_complete = c;
		e.cmd_timeout = t;
		e.cmd_error = er;
		e.resp_word = w;
		return e;
	endfunction

	function automatic evt_t ev_data(input logic [5:0] idx, input logic [7:0] b);
		evt_t e;
		e = random_fill();
		e.opcode = OP_DATA;
		e.data_index = idx;
		e.data_byte = b;
		return e;
	endfunction

	function automatic evt_t ev_read(input logic [31:0] blk);
		evt_t e;
		e = random_fill();
		e.opcode = OP_READ;
		e.block_index = blk;
		return e;
	endfunction

	// Pick the next request from the modeled phase, so that most of the stream
	// is a plausible card conversation and the rest is noise.
	function automatic evt_t next_request();
		evt_t e;
		int unsigned r;
		int unsigned s;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		s = $urandom_range(0, 99);
		if (r < 10) begin
			e = random_fill();
			e.opcode = opcode_t'(3'($urandom_range(0, 7)));
			return e;
		end
		case (seq_phase)
			PH_IDLE, PH_FAILED: e = (s < 80) ? ev_start() : ev_read($urandom);
			PH_CMD0: e = ev_result(coin(), coin(), coin(), $urandom);
			PH_CMD8: begin
				if (s < 20)
					e = ev_tick();
				else if (s < 60)
					e = ev_result(1'b1, 1'b0, flip(10), ARG_CMD8_CHECK);
				else if (s < 85)
					e = ev_result(coin(), 1'b1, coin(), $urandom);
				else
					e = ev_result(coin(), 1'b0, coin(), $urandom);
			end
			PH_GAP8, PH_GAP41: e = (s < 90) ? ev_tick() : ev_result(coin(), coin(),
				coin(), $urandom);
			PH_CMD55I: begin
				if (s < 15)
					e = ev_tick();
				else if (s < 75)
					e = ev_result(1'b1, 1'b0, flip(10), $urandom);
				else if (s < 92)
					e = ev_result(1'b0, 1'b1, coin(), $urandom);
				else
					e = ev_result(1'b0, 1'b0, coin(), $urandom);
			end
			PH_ACMD41: begin
				// busy and CCS bits are random in the response word
				if (s < 15)
					e = ev_tick();
				else if (s < 80)
					e = ev_result(1'b1, flip(5), flip(10), $urandom);
				else if (s < 92)
					e = ev_result(coin(), 1'b1, coin(), $urandom);
				else
					e = ev_result(1'b0, 1'b0, coin(), $urandom);
			end
			PH_CMD6: begin
				if (s < 70) begin
					b = 8'($urandom);
					case ($urandom_range(0, 2))
						0: begin
							if (flip(80))
								b[1] = 1'b1;
							e = ev_data(STATUS_IDX_D, b);
						end
						1: begin
							if (flip(80))
								b[3:0] = 4'h1;
							e = ev_data(STATUS_IDX_10, b);
						end
						default: e = ev_data(6'($urandom), b);
					endcase
				end else begin
					e = ev_result(flip(85), flip(10), flip(10), $urandom);
				end
			end
			PH_READY: begin
				if (s < 80) begin
					e = ev_read(flip(10) ? 32'hffff_ffff : $urandom);
				end else begin
					e = random_fill();
					e.opcode = opcode_t'(3'($urandom_range(1, 3)));
				end
			end
			default: begin
				if (s < 90)
					e = ev_result(1'b1, flip(5), flip(10), $urandom);
				else
					e = ev_result(1'b0, coin(), coin(), $urandom);
			end
		endcase
		return e;
	endfunction

	// mostly back to back or short gaps, now and then a long one
	function automatic int unsigned pick_gap(input bit steady);
		int unsigned s;
		if (steady)
			return 0;
		s = $urandom_range(0, 99);
		if (s < 55)
			return 0;
		if (s < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// Driving tasks
	// ------------------------------------------------------------------

	// Offer one request, hold it until accepted, then model it and, when paced, maybe pause.
	task automatic send_request(input evt_t e, input bit paced);
		int unsigned gap;
		evt_ch.valid <= 1'b1;
		evt_ch.data <= e;
		do @(posedge clk); while (!evt_ch.ready);
		advance_sequencer(e);
		gap = paced ? pick_gap(evt_steady) : 0;
		if (gap != 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait for every predicted result, then let silent requests
	// clear the block.
	task automatic settle();
		evt_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			CFG_RETRY_WINDOW: window_ms = value;
			CFG_RETRY_GAP: gap_ms = value[7:0];
			CFG_WIDE_BUS: wide_en = value[0];
			default: hs_en = value[0];
		endcase
	endtask

	// Upper data bits of the narrow registers carry noise the block must drop.
	task automatic set_config(input logic [15:0] window, input logic [7:0] gap,
			input logic wide, input logic hs);
		settle();
		write_register(CFG_RETRY_WINDOW, window);
		write_register(CFG_RETRY_GAP, {8'($urandom), gap});
		write_register(CFG_WIDE_BUS, {15'($urandom), wide});
		write_register(CFG_HIGH_SPEED, {15'($urandom), hs});
		cfg_we <= 1'b0;
	endtask

	task automatic run_random_phase(input int unsigned count);
		repeat (count) send_request(next_request(), 1'b1);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Full bring-up of a version 2, block-addressed card at reset settings,
	// then reads, a failed read and the sticky failed state.
	task automatic test_bring_up_defaults();
		send_request(ev_start(), 1'b1);
		send_request(ev_result(1'b0, 1'b1, 1'b1, $urandom), 1'b1);
		// one CMD8 timeout, reissued after the gap of five ticks
		send_request(ev_result(1'b0, 1'b1, 1'b0, 32'd0), 1'b1);
		repeat (5) send_request(ev_tick(), 1'b1);
		send_request(ev_result(1'b1, 1'b0, 1'b0, ARG_CMD8_CHECK), 1'b1);
		send_request(ev_result(1'b1, 1'b0, 1'b0, 32'd0), 1'b1);
		send_request(ev_result(1'b1, 1'b0, 1'b0, 32'hc0ff_8000), 1'b1);
		send_request(ev_result(1'b1, 1'b0, 1'b0, 32'd0), 1'b1);
		send_request(ev_result(1'b1, 1'b0, 1'b0, 32'hffff_0000), 1'b1);
		repeat (5) send_request(ev_result(1'b1, 1'b0, 1'b0, 32'hffff_ffff), 1'b1);
		// two switch passes that both grant high speed
		send_request(ev_data(STATUS_IDX_D, 8'hff), 1'b1);
		send_request(ev_data(STATUS_IDX_10, 8'h01), 1'b1);
		send_request(ev_result(1'b1, 1'b0, 1'b0, 32'd0), 1'b1);
		send_request(ev_data(STATUS_IDX_D, 8'h02), 1'b1);
		send_request(ev_data(STATUS_IDX_10, 8'hf1), 1'b1);
		send_request(ev_result(1'b1, 1'b0, 1'b0, 32'd0), 1'b1);
		send_request(ev_read(32'hffff_ffff), 1'b1);
		send_request(ev_result(1'b1, 1'b0, 1'b0, 32'd0), 1'b1);
		send_request(ev_read(32'd0), 1'b1);
		send_request(ev_result(1'b0, 1'b1, 1'b0, 32'd0), 1'b1);
		send_request(ev_read($urandom), 1'b1);
	endtask

	// Both ends of every register, with random conversations over them.
	task automatic test_config_extremes();
		set_config(16'd0, 8'd0, 1'b0, 1'b0);
		run_random_phase(60);
		set_config(16'hffff, 8'hff, 1'b1, 1'b1);
		run_random_phase(60);
	endtask

	// Short windows and gaps so retry loops expire often; idling varies by phase.
	task automatic test_random_settings();
		repeat (5) begin
			evt_steady = flip(25);
			res_steady = flip(25);
			set_config(16'($urandom_range(0, 15)), 8'($urandom_range(0, 3)), coin(),
				coin());
			run_random_phase(55);
		end
		evt_steady = 1'b0;
		res_steady = 1'b0;
	endtask

	// Tiny window and one-tick gap: the CMD8 loop runs out, the card is taken as
	// version 1, then the ACMD41 loop runs out on a busy card that shows CCS.
	task automatic test_window_expiry();
		set_config(16'd3, 8'd1, 1'b1, 1'b1);
		send_request(ev_start(), 1'b1);
		send_request(ev_result(1'b1, 1'b0, 1'b0, 32'd0), 1'b1);
		repeat (5) begin
			send_request(ev_result(1'b0, 1'b1, 1'b0, 32'd0), 1'b1);
			send_request(ev_tick(), 1'b1);
		end
		repeat (5) begin
			send_request(ev_result(1'b1, 1'b0, 1'b0, 32'd0), 1'b1);
			send_request(ev_result(1'b1, 1'b0, 1'b0, 32'h40ff_8000), 1'b1);
			send_request(ev_tick(), 1'b1);
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random back-pressure and in-order comparison
	// ------------------------------------------------------------------
	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want,
				got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: expected none, actual kind %0d cmd %0d",
					$time, res_ch.data.kind, res_ch.data.cmd_index);
				errors++;
			end else begin
				head_result = pending_results.pop_front();
				compare_field("kind", head_result.kind, res_ch.data.kind);
				compare_field("cmd_index", head_result.cmd_index, res_ch.data.cmd_index);
				compare_field("cmd_arg", head_result.cmd_arg, res_ch.data.cmd_arg);
				compare_field("resp_type", head_result.resp_type, res_ch.data.resp_type);
				compare_field("check_index", head_result.check_index,
					res_ch.data.check_index);
				compare_field("check_crc", head_result.check_crc, res_ch.data.check_crc);
				compare_field("has_data", head_result.has_data, res_ch.data.has_data);
				compare_field("clock_divider", head_result.clock_divider,
					res_ch.data.clock_divider);
				compare_field("fail_code", head_result.fail_code, res_ch.data.fail_code);
				compare_field("last", head_result.last, res_ch.data.last);
			end
		end
		// hold ready low for a stall, else raise it and maybe start the next stall
		if (res_stall_left != 0) begin
			res_ch.ready <= 1'b0;
			res_stall_left--;
		end else begin
			res_ch.ready <= 1'b1;
			if (!res_steady && flip(20))
				res_stall_left = flip(85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		end
	end

	// Abort when neither channel has moved for too long.
	always @(posedge clk) begin
		if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t no request or result accepted for %0d cycles", $time,
				idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		// drive every block input to a known value before reset
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		evt_ch.valid = 1'b0;
		evt_ch.data = '0;
		res_ch.ready = 1'b0;
		errors = 0;
		idle_cycles = 0;
		res_stall_left = 0;
		evt_steady = 1'b0;
		res_steady = 1'b0;

		// model starts from the block's reset values
		window_ms = RESET_RETRY_WINDOW;
		gap_ms = RESET_RETRY_GAP;
		wide_en = 1'b1;
		hs_en = 1'b1;
		seq_phase = PH_IDLE;
		ms_elapsed = 16'd0;
		gap_left = 8'd0;
		card_v2 = 1'b0;
		rca_latched = 16'd0;
		switch_pass = 2'd0;
		sw_byte_d = 8'd0;
		sw_byte_10 = 8'd0;
		addr_shift = SHIFT_BYTE_ADDR;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bring_up_defaults();
		test_config_extremes();
		test_random_settings();
		test_window_expiry();

		// drain, then give the block time to show any stray result
		settle();
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t %0d predicted results never arrived", $time,
				pending_results.size());
			errors++;
		end
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
